### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL; included by the top-level decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define PBC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: %m");

// Next-cycle implication, checked through reset too.
`define PBC_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: %m");

`endif

### hw/rtl/pbc_pkg.sv
package pbc_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_PLANES_DEF = 8;

   localparam int WIDTH_CFG_W  = 11;
   localparam int HEIGHT_W     = 16;
   localparam int PLANES_CFG_W = 4;
   localparam int BYTE_W       = 8;
   localparam int CNT_W        = 8;
   localparam int WORD_W       = 16;
   localparam int LANE_W       = 64;
   localparam int LINE_W       = 2 * LANE_W;
   localparam int WCOL_W       = 6;
   localparam int VCNT_W       = 5;
   localparam int PSH_W        = 3;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RST  = 11'd320;
   localparam logic [HEIGHT_W-1:0]     HEIGHT_RST = 16'd200;
   localparam logic [PLANES_CFG_W-1:0] PLANES_RST = 4'd5;
   localparam logic                    RLE_RST    = 1'b1;

   localparam logic [BYTE_W-1:0] HDR_NOP  = 8'h80;
   localparam logic [BYTE_W:0]   REP_BASE = 9'd257;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_PLANES = 2'd2,
      CSR_RLE    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LITERAL,
      PH_REPEAT
   } rle_phase_type;

   typedef struct packed {
      logic [WIDTH_CFG_W-1:0]  image_width;
      logic [HEIGHT_W-1:0]     image_height;
      logic [PLANES_CFG_W-1:0] num_planes;
      logic                    rle_enable;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [BYTE_W-1:0] body_byte;
      logic [CNT_W-1:0]  count;
   } cmd_type;

   typedef struct packed {
      logic has_word;
      logic emit;
      logic last;
      logic done;
   } word_ctl_type;

endpackage

### hw/rtl/pbc_front.sv
module pbc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [pbc_pkg::BYTE_W-1:0] req_body_byte,
   input  logic                      req_start_of_body,
   input  logic                      rle_enable,
   output logic                      push_valid,
   input  logic                      push_ready,
   output pbc_pkg::cmd_type          push_cmd
);
   import pbc_pkg::*;

   rle_phase_type     phase_ff, phase_in, phase_cur;
   logic [CNT_W-1:0]  rem_ff, rem_in, rem_cur;
   logic              accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   always_comb begin
      phase_cur = req_start_of_body ? PH_HEADER : phase_ff;
      rem_cur   = req_start_of_body ? '0 : rem_ff;
   end

   always_comb begin
      phase_in = phase_ff;
      rem_in   = rem_ff;
      if (accept) begin
         phase_in = phase_cur;
         rem_in   = rem_cur;
         if (rle_enable) begin
            case (phase_cur)
               PH_LITERAL: begin
                  if (rem_cur == '0) begin
                     phase_in = PH_HEADER;
                  end else begin
                     rem_in = rem_cur - CNT_W'(1);
                  end
               end
               PH_REPEAT: begin
                  rem_in   = '0;
                  phase_in = PH_HEADER;
               end
               PH_HEADER: begin
                  if (!req_body_byte[BYTE_W-1]) begin
                     rem_in   = req_body_byte;
                     phase_in = PH_LITERAL;
                  end else if (req_body_byte != HDR_NOP) begin
                     rem_in   = CNT_W'(REP_BASE - {1'b0, req_body_byte});
                     phase_in = PH_REPEAT;
                  end
               end
               default: begin
                  phase_in = PH_HEADER;
               end
            endcase
         end
      end
   end

   always_comb begin
      push_cmd.start     = req_start_of_body;
      push_cmd.body_byte = req_body_byte;
      push_cmd.count     = '0;
      if (!rle_enable) begin
         push_cmd.count = CNT_W'(1);
      end else begin
         case (phase_cur)
            PH_LITERAL: push_cmd.count = CNT_W'(1);
            PH_REPEAT:  push_cmd.count = rem_cur;
            default:    push_cmd.count = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         rem_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
      end
   end

endmodule

### hw/rtl/pbc_queue.sv
module pbc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  pbc_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop,
   output pbc_pkg::cmd_type pop_cmd
);
   import pbc_pkg::*;

   localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [QPW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != QCW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/pbc_seq.sv
module pbc_seq #(
   parameter int MAX_WIDTH  = pbc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_PLANES = pbc_pkg::MAX_PLANES_DEF,
   localparam int MAX_WORDS = (MAX_WIDTH + 15) / 16,
   localparam int CLW       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pbc_pkg::cfg_type            cfg,
   input  logic                        q_valid,
   input  pbc_pkg::cmd_type            q_cmd,
   output logic                        q_pop,
   output logic                        ent_valid,
   input  logic                        ent_ready,
   output pbc_pkg::word_ctl_type       ent_ctl,
   output logic [pbc_pkg::WORD_W-1:0]  ent_word,
   output logic [CLW-1:0]              ent_col,
   output logic [pbc_pkg::PSH_W-1:0]   ent_plane,
   output logic [pbc_pkg::HEIGHT_W-1:0] ent_row,
   output logic [pbc_pkg::WCOL_W-1:0]  ent_wcol,
   output logic [pbc_pkg::VCNT_W-1:0]  ent_vcnt
);
   import pbc_pkg::*;

   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int CW  = ((WW > WIDTH_CFG_W) ? WW : WIDTH_CFG_W) + 1;
   localparam int PPW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

   logic                    cur_v_ff, cur_v_in;
   logic [BYTE_W-1:0]       byte_ff, byte_in, held_ff, held_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    half_ff, half_in;
   logic [CLW-1:0]          wp_ff, wp_in;
   logic [PPW-1:0]          pl_ff, pl_in;
   logic [HEIGHT_W-1:0]     row_ff, row_in;
   logic                    fin_ff, fin_in;

   logic [CW-1:0]           w_ext, eff_w, words, base, rem_w;
   logic [PLANES_CFG_W-1:0] eff_p, pl_next;
   logic [HEIGHT_W:0]       row_next;
   logic                    wrap_w, wrap_p, wrap_r, emit_c, step, run_end;
   logic [WORD_W-1:0]       raw_word;

   always_comb begin
      w_ext = CW'(cfg.image_width);
      if (w_ext == '0) begin
         eff_w = CW'(1);
      end else if (w_ext > CW'(MAX_WIDTH)) begin
         eff_w = CW'(MAX_WIDTH);
      end else begin
         eff_w = w_ext;
      end
      words = (eff_w + CW'(15)) >> 4;
      if (cfg.num_planes == '0) begin
         eff_p = PLANES_CFG_W'(1);
      end else if (cfg.num_planes > PLANES_CFG_W'(MAX_PLANES)) begin
         eff_p = PLANES_CFG_W'(MAX_PLANES);
      end else begin
         eff_p = cfg.num_planes;
      end
      base     = CW'({wp_ff, 4'b0000});
      rem_w    = eff_w - base;
      ent_vcnt = '0;
      if (eff_w > base) begin
         ent_vcnt = (rem_w > CW'(16)) ? VCNT_W'(16) : VCNT_W'(rem_w);
      end
      raw_word = {held_ff, byte_ff};
      for (int i = 0; i < WORD_W; i++) begin
         ent_word[WORD_W-1-i] = raw_word[WORD_W-1-i] && (VCNT_W'(i) < ent_vcnt);
      end
      wrap_w   = (CW'(wp_ff) + CW'(1)) >= words;
      pl_next  = PLANES_CFG_W'(pl_ff) + PLANES_CFG_W'(1);
      wrap_p   = pl_next >= eff_p;
      emit_c   = pl_next == eff_p;
      row_next = {1'b0, row_ff} + (HEIGHT_W+1)'(1);
      wrap_r   = row_next >= {1'b0, cfg.image_height};
   end

   assign step = cur_v_ff && ent_ready;

   always_comb begin
      cur_v_in = cur_v_ff;
      byte_in  = byte_ff;
      cnt_in   = cnt_ff;
      half_in  = half_ff;
      held_in  = held_ff;
      wp_in    = wp_ff;
      pl_in    = pl_ff;
      row_in   = row_ff;
      fin_in   = fin_ff;
      run_end  = 1'b0;
      if (step) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (!half_ff) begin
            held_in = byte_ff;
            half_in = 1'b1;
            run_end = (cnt_ff == CNT_W'(1));
         end else begin
            half_in = 1'b0;
            if (wrap_w) begin
               wp_in = '0;
               if (wrap_p) begin
                  pl_in  = '0;
                  row_in = row_next[HEIGHT_W-1:0];
                  if (wrap_r) begin
                     fin_in = 1'b1;
                  end
               end else begin
                  pl_in = pl_ff + PPW'(1);
               end
            end else begin
               wp_in = wp_ff + CLW'(1);
            end
            run_end = (cnt_ff == CNT_W'(1)) || (wrap_w && wrap_p && wrap_r);
         end
         cur_v_in = !run_end;
      end
      q_pop = q_valid && (!cur_v_ff || (step && run_end));
      if (q_pop) begin
         if (q_cmd.start) begin
            half_in = 1'b0;
            held_in = '0;
            wp_in   = '0;
            pl_in   = '0;
            row_in  = '0;
            fin_in  = 1'b0;
         end
         if (cfg.image_height == '0) begin
            fin_in = 1'b1;
         end
         cur_v_in = (q_cmd.count != '0) && !fin_in;
         byte_in  = q_cmd.body_byte;
         cnt_in   = q_cmd.count;
      end
   end

   always_comb begin
      ent_valid        = step && (half_ff || run_end);
      ent_ctl.has_word = half_ff;
      ent_ctl.emit     = half_ff && emit_c;
      ent_ctl.last     = run_end;
      ent_ctl.done     = wrap_r && wrap_w;
      ent_col          = wp_ff;
      ent_plane        = PSH_W'(pl_ff);
      ent_row          = row_ff;
      ent_wcol         = WCOL_W'(wp_ff);
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      cnt_ff  <= cnt_in;
      held_ff <= held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_v_ff <= 1'b0;
         half_ff  <= 1'b0;
         wp_ff    <= '0;
         pl_ff    <= '0;
         row_ff   <= '0;
         fin_ff   <= 1'b0;
      end else begin
         cur_v_ff <= cur_v_in;
         half_ff  <= half_in;
         wp_ff    <= wp_in;
         pl_ff    <= pl_in;
         row_ff   <= row_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

### hw/rtl/pbc_pixel.sv
module pbc_pixel #(
   parameter int MAX_WIDTH = pbc_pkg::MAX_WIDTH_DEF,
   localparam int MAX_WORDS = (MAX_WIDTH + 15) / 16,
   localparam int CLW       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  pbc_pkg::word_ctl_type        in_ctl,
   input  logic [pbc_pkg::WORD_W-1:0]   in_word,
   input  logic [CLW-1:0]               in_col,
   input  logic [pbc_pkg::PSH_W-1:0]    in_plane,
   input  logic [pbc_pkg::HEIGHT_W-1:0] in_row,
   input  logic [pbc_pkg::WCOL_W-1:0]   in_wcol,
   input  logic [pbc_pkg::VCNT_W-1:0]   in_vcnt,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [pbc_pkg::LANE_W-1:0]   rsp_pixels_low,
   output logic [pbc_pkg::LANE_W-1:0]   rsp_pixels_high,
   output logic [pbc_pkg::HEIGHT_W-1:0] rsp_row_number,
   output logic [pbc_pkg::WCOL_W-1:0]   rsp_word_column,
   output logic [pbc_pkg::VCNT_W-1:0]   rsp_valid_pixels,
   output logic                         rsp_last_of_run,
   output logic                         rsp_image_done
);
   import pbc_pkg::*;

   logic [LINE_W-1:0]   store_mem [MAX_WORDS];

   logic                p1_v_ff, p1_v_in;
   word_ctl_type        p1_ctl_ff;
   logic [WORD_W-1:0]   p1_word_ff;
   logic [CLW-1:0]      p1_col_ff;
   logic [PSH_W-1:0]    p1_pl_ff;
   logic [HEIGHT_W-1:0] p1_row_ff;
   logic [WCOL_W-1:0]   p1_wcol_ff;
   logic [VCNT_W-1:0]   p1_vcnt_ff;
   logic [LINE_W-1:0]   rd_ff, byp_data_ff;
   logic                byp_ff;

   logic                pend_v_ff, pend_v_in, pend_fin_ff, pend_fin_in;
   logic [LINE_W-1:0]   pend_data_ff;
   logic [HEIGHT_W-1:0] pend_row_ff;
   logic [WCOL_W-1:0]   pend_wcol_ff;
   logic [VCNT_W-1:0]   pend_vcnt_ff;
   logic                pend_done_ff;

   logic                out_v_ff, out_v_in, out_last_ff, out_done_ff;
   logic [LINE_W-1:0]   out_data_ff;
   logic [HEIGHT_W-1:0] out_row_ff;
   logic [WCOL_W-1:0]   out_wcol_ff;
   logic [VCNT_W-1:0]   out_vcnt_ff;

   logic                out_free, pend_go, p1_cons, p1_load, p1_write, take_emit;
   logic [LINE_W-1:0]   old_line, merged;

   always_comb begin
      out_free  = !out_v_ff || rsp_ready;
      pend_go   = pend_v_ff && out_free && (pend_fin_ff || (p1_v_ff && p1_ctl_ff.emit));
      p1_cons   = p1_v_ff && (!p1_ctl_ff.emit || !pend_v_ff || pend_go);
      in_ready  = !p1_v_ff || p1_cons;
      p1_load   = in_valid && in_ready;
      p1_write  = p1_cons && p1_ctl_ff.has_word;
      take_emit = p1_cons && p1_ctl_ff.emit;
   end

   always_comb begin
      old_line = byp_ff ? byp_data_ff : rd_ff;
      for (int i = 0; i < WORD_W; i++) begin
         merged[8*i +: 8] = ((p1_pl_ff == '0) ? 8'h00 : old_line[8*i +: 8])
                          | (8'(p1_word_ff[WORD_W-1-i]) << p1_pl_ff);
      end
   end

   always_comb begin
      p1_v_in = p1_v_ff;
      if (p1_load) begin
         p1_v_in = 1'b1;
      end else if (p1_cons) begin
         p1_v_in = 1'b0;
      end
      pend_v_in   = pend_v_ff;
      pend_fin_in = pend_fin_ff;
      if (take_emit) begin
         pend_v_in   = 1'b1;
         pend_fin_in = p1_ctl_ff.last;
      end else if (pend_go) begin
         pend_v_in = 1'b0;
      end else if (p1_cons && p1_ctl_ff.last) begin
         pend_fin_in = 1'b1;
      end
      out_v_in = out_v_ff;
      if (pend_go) begin
         out_v_in = 1'b1;
      end else if (rsp_ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (p1_write) begin
         store_mem[p1_col_ff] <= merged;
      end
      if (p1_load) begin
         rd_ff <= store_mem[in_col];
      end
   end

   always_ff @(posedge clock) begin
      if (p1_load) begin
         p1_ctl_ff   <= in_ctl;
         p1_word_ff  <= in_word;
         p1_col_ff   <= in_col;
         p1_pl_ff    <= in_plane;
         p1_row_ff   <= in_row;
         p1_wcol_ff  <= in_wcol;
         p1_vcnt_ff  <= in_vcnt;
         byp_ff      <= p1_write && (p1_col_ff == in_col);
         byp_data_ff <= merged;
      end
      if (take_emit) begin
         pend_data_ff <= merged;
         pend_row_ff  <= p1_row_ff;
         pend_wcol_ff <= p1_wcol_ff;
         pend_vcnt_ff <= p1_vcnt_ff;
         pend_done_ff <= p1_ctl_ff.done;
      end
      if (pend_go) begin
         out_data_ff <= pend_data_ff;
         out_row_ff  <= pend_row_ff;
         out_wcol_ff <= pend_wcol_ff;
         out_vcnt_ff <= pend_vcnt_ff;
         out_done_ff <= pend_done_ff;
         out_last_ff <= pend_fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff     <= 1'b0;
         pend_v_ff   <= 1'b0;
         pend_fin_ff <= 1'b0;
         out_v_ff    <= 1'b0;
      end else begin
         p1_v_ff     <= p1_v_in;
         pend_v_ff   <= pend_v_in;
         pend_fin_ff <= pend_fin_in;
         out_v_ff    <= out_v_in;
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_pixels_low   = out_data_ff[LANE_W-1:0];
   assign rsp_pixels_high  = out_data_ff[LINE_W-1:LANE_W];
   assign rsp_row_number   = out_row_ff;
   assign rsp_word_column  = out_wcol_ff;
   assign rsp_valid_pixels = out_vcnt_ff;
   assign rsp_last_of_run  = out_last_ff;
   assign rsp_image_done   = out_done_ff;

endmodule

### hw/rtl/packbits_planar_to_chunky_decoder.sv
// Path: an accepted item passes the command queue, the byte sequencer, the pixel stage and
// the pending and output registers; a word inside a run waits in the pending register for
// the next entry. Throughput: one decoded byte per cycle while the pixel stage is ready; a
// repeat run can hold back input once the queue is full, while the byte sequencer expands it.
// Reset: synchronous, active high; clears decoder, queue and positions, and
// loads the register defaults. The line store is not cleared.
`include "assert_macros.svh"

module packbits_planar_to_chunky_decoder #(
   parameter int MAX_WIDTH  = pbc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_PLANES = pbc_pkg::MAX_PLANES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pbc_pkg::BYTE_W-1:0]     req_body_byte,
   input  logic                           req_start_of_body,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pbc_pkg::LANE_W-1:0]     rsp_pixels_low,
   output logic [pbc_pkg::LANE_W-1:0]     rsp_pixels_high,
   output logic [pbc_pkg::HEIGHT_W-1:0]   rsp_row_number,
   output logic [pbc_pkg::WCOL_W-1:0]     rsp_word_column,
   output logic [pbc_pkg::VCNT_W-1:0]     rsp_valid_pixels,
   output logic                           rsp_last_of_run,
   output logic                           rsp_image_done,
   input  logic                           csr_write_enable,
   input  logic [pbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pbc_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import pbc_pkg::*;

   localparam int MAX_WORDS = (MAX_WIDTH + 15) / 16;
   localparam int CLW       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

   cfg_type             cfg_ff, cfg_in;
   logic                push_valid, push_ready, q_valid, q_pop;
   cmd_type             push_cmd, q_cmd;
   logic                ent_valid, ent_ready;
   word_ctl_type        ent_ctl;
   logic [WORD_W-1:0]   ent_word;
   logic [CLW-1:0]      ent_col;
   logic [PSH_W-1:0]    ent_plane;
   logic [HEIGHT_W-1:0] ent_row;
   logic [WCOL_W-1:0]   ent_wcol;
   logic [VCNT_W-1:0]   ent_vcnt;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_WIDTH:  cfg_in.image_width  = csr_write_data[WIDTH_CFG_W-1:0];
            CSR_HEIGHT: cfg_in.image_height = csr_write_data[HEIGHT_W-1:0];
            CSR_PLANES: cfg_in.num_planes   = csr_write_data[PLANES_CFG_W-1:0];
            CSR_RLE:    cfg_in.rle_enable   = csr_write_data[0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= WIDTH_RST;
         cfg_ff.image_height <= HEIGHT_RST;
         cfg_ff.num_planes   <= PLANES_RST;
         cfg_ff.rle_enable   <= RLE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pbc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_body_byte     (req_body_byte),
      .req_start_of_body (req_start_of_body),
      .rle_enable        (cfg_ff.rle_enable),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_cmd          (push_cmd)
   );

   pbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_cmd    (q_cmd)
   );

   pbc_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_PLANES (MAX_PLANES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .ent_valid (ent_valid),
      .ent_ready (ent_ready),
      .ent_ctl   (ent_ctl),
      .ent_word  (ent_word),
      .ent_col   (ent_col),
      .ent_plane (ent_plane),
      .ent_row   (ent_row),
      .ent_wcol  (ent_wcol),
      .ent_vcnt  (ent_vcnt)
   );

   pbc_pixel #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_pixel (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (ent_valid),
      .in_ready         (ent_ready),
      .in_ctl           (ent_ctl),
      .in_word          (ent_word),
      .in_col           (ent_col),
      .in_plane         (ent_plane),
      .in_row           (ent_row),
      .in_wcol          (ent_wcol),
      .in_vcnt          (ent_vcnt),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixels_low   (rsp_pixels_low),
      .rsp_pixels_high  (rsp_pixels_high),
      .rsp_row_number   (rsp_row_number),
      .rsp_word_column  (rsp_word_column),
      .rsp_valid_pixels (rsp_valid_pixels),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_image_done   (rsp_image_done)
   );

   `PBC_ASSERT_NOW(a_done_ends_item, clock, reset, rsp_valid && rsp_image_done, rsp_last_of_run)
   `PBC_ASSERT_NOW(a_vcnt_range, clock, reset, rsp_valid, rsp_valid_pixels <= VCNT_W'(16))
   `PBC_ASSERT_NEXT(a_reset_idle, clock, reset, !rsp_valid)

endmodule
